// ===== rtl/sssfp_pkg.sv =====
// Shared types, codes and constants of the servo status frame parser.
package sssfp_pkg;

  // Build-time defaults
  localparam int MAX_PAYLOAD_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 3;
  localparam int PAYLOAD_W = 64;
  localparam int LEN_W     = 4;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ARM  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] EXPECTED_ID_RST = 8'd1;
  localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 4'd0;
  localparam logic [TICK_W-1:0] TIMEOUT_RST     = 16'd50;

  // Header marker byte
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

  // Result codes
  localparam logic [CODE_W-1:0] RC_OK      = 3'd0;
  localparam logic [CODE_W-1:0] RC_ID      = 3'd1;
  localparam logic [CODE_W-1:0] RC_LEN     = 3'd2;
  localparam logic [CODE_W-1:0] RC_STATUS  = 3'd3;
  localparam logic [CODE_W-1:0] RC_SUM     = 3'd4;
  localparam logic [CODE_W-1:0] RC_TIMEOUT = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]    result_code;
    logic [PAYLOAD_W-1:0] payload_data;
  } res_item_t;

  // Item class handed from the front to the back
  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_TICK,
    KIND_ARM
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } work_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_STATUS,
    PH_DATA,
    PH_CHECK
  } phase_t;

endpackage

// ===== rtl/servo_status_frame_parser.sv =====
// Top level of the servo status frame parser.
//
// Takes one item per beat on a queue-style input (push/full): a received byte,
// a timer tick, or an arm that starts a new response wait and loads the tick
// deadline. After arm the parser hunts for two back-to-back 0xFF bytes, then
// checks id, length and status against the configuration, collects the
// payload and verifies the inverted 8-bit checksum. Each wait ends in at most
// one result beat (ok, id/length/status error, bad checksum or timeout); an
// arm during a wait restarts the hunt with no result. After a result, bytes
// and ticks are ignored until the next arm. Results are read from a queue-style
// output (empty/pop); payload bytes land first byte in bits 63..56 and are
// zero unless the code is ok. Throughput is one item per clock while full is
// low: the front classifies the item into a QUEUE_DEPTH-entry queue, the
// back runs the frame state machine on the queue head and writes a
// QUEUE_DEPTH-entry result queue; the completing item is registered in the
// work queue and its result in the result queue before reaching the output
// ports. The front only stalls (full high) when both queues back up behind an
// unread result. Configuration writes are always taken (cfg_ready high) and
// must only be issued while no wait is in progress; write index 3 is ignored.
module servo_status_frame_parser import sssfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Item input
  input  logic                 push,
  input  in_item_t             item,
  output logic                 full,
  // Result output
  output res_item_t            result,
  output logic                 empty,
  input  logic                 pop,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Hand-off between front and back
  work_item_t work;
  logic       work_empty;
  logic       take;

  // Classify and buffer incoming beats
  sssfp_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .take       (take),
    .work       (work),
    .work_empty (work_empty)
  );

  // Advance the frame state machine and queue results
  sssfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (work),
    .work_empty (work_empty),
    .take       (take),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== rtl/sssfp_queue.sv =====
// Small flip-flop FIFO used between the parser stages and at the result port.
module sssfp_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sssfp_front.sv =====
// Front end: classify incoming items and queue them for the parser.
module sssfp_front import sssfp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  in_item_t   item,
  output logic       full,
  input  logic       take,
  output work_item_t work,
  output logic       work_empty
);

  work_item_t cls;
  logic       keep;

  // Decode opcode; drop the unused code
  always_comb begin
    cls.data = item.rx_byte;
    cls.kind = KIND_BYTE;
    keep     = 1'b1;
    unique case (item.opcode)
      OP_BYTE: cls.kind = KIND_BYTE;
      OP_TICK: cls.kind = KIND_TICK;
      OP_ARM:  cls.kind = KIND_ARM;
      default: keep     = 1'b0;
    endcase
  end

  sssfp_queue #(
    .T     (work_item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (cls),
    .full  (full),
    .pop   (take),
    .rdata (work),
    .empty (work_empty)
  );

endmodule

// ===== rtl/sssfp_back.sv =====
// Back end: frame state machine, checksum, payload capture, timer and result queue.
module sssfp_back import sssfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  work_item_t           work,
  input  logic                 work_empty,
  output logic                 take,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output res_item_t            result,
  output logic                 empty,
  input  logic                 pop
);

  localparam int STORE_W = MAX_PAYLOAD * BYTE_W;
  localparam int IDX_W   = $clog2(MAX_PAYLOAD + 1);

  // Configuration
  logic [BYTE_W-1:0] match_id;
  logic [LEN_W-1:0]  expected_len;
  logic [TICK_W-1:0] timeout_ticks;

  // Frame state
  phase_t             phase, phase_next;
  logic               last_ff, last_ff_next;
  logic               id_wrong, id_wrong_next;
  logic               len_wrong, len_wrong_next;
  logic [BYTE_W-1:0]  run_sum, run_sum_next;
  logic [STORE_W-1:0] store, store_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [TICK_W-1:0]  ticks_left, ticks_left_next;

  logic              res_full;
  logic              res_push;
  res_item_t         res_data;
  logic              is_hdr;
  logic              last_tick;
  logic [IDX_W-1:0]  idx_inc;
  logic              data_done;
  logic              hdr_error;
  logic [PAYLOAD_W-1:0] payload_wide;

  assign cfg_ready = 1'b1;
  assign take      = !work_empty && !res_full;
  assign is_hdr    = (work.data == HDR_BYTE);
  assign last_tick = (ticks_left <= TICK_W'(1));
  assign idx_inc   = idx + 1'b1;
  assign data_done = (BYTE_W'(idx_inc) >= BYTE_W'(expected_len));
  assign hdr_error = id_wrong || len_wrong || (work.data != '0);

  always_comb begin
    payload_wide = '0;
    payload_wide[PAYLOAD_W-1 -: STORE_W] = store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_id      <= EXPECTED_ID_RST;
      expected_len  <= PAYLOAD_LEN_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPECTED_ID: match_id      <= cfg_data[BYTE_W-1:0];
        REG_PAYLOAD_LEN: expected_len  <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT:     timeout_ticks <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (work.kind)
        KIND_ARM: phase_next = PH_HUNT;
        KIND_TICK: begin
          if (phase != PH_IDLE && last_tick) phase_next = PH_IDLE;
        end
        KIND_BYTE: begin
          unique case (phase)
            PH_IDLE:   phase_next = PH_IDLE;
            PH_HUNT:   if (last_ff && is_hdr) phase_next = PH_ID;
            PH_ID:     phase_next = PH_LEN;
            PH_LEN:    phase_next = PH_STATUS;
            PH_STATUS: begin
              if (hdr_error) phase_next = PH_IDLE;
              else if (expected_len == '0) phase_next = PH_CHECK;
              else phase_next = PH_DATA;
            end
            PH_DATA:   if (data_done) phase_next = PH_CHECK;
            PH_CHECK:  phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Datapath and results
  always_comb begin
    last_ff_next    = last_ff;
    id_wrong_next   = id_wrong;
    len_wrong_next  = len_wrong;
    run_sum_next    = run_sum;
    store_next      = store;
    idx_next        = idx;
    ticks_left_next = ticks_left;
    res_push        = 1'b0;
    res_data        = '0;
    if (take) begin
      unique case (work.kind)
        KIND_ARM: begin
          last_ff_next    = 1'b0;
          id_wrong_next   = 1'b0;
          len_wrong_next  = 1'b0;
          run_sum_next    = '0;
          store_next      = '0;
          idx_next        = '0;
          ticks_left_next = timeout_ticks;
        end
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            if (last_tick) begin
              ticks_left_next      = '0;
              res_push             = 1'b1;
              res_data.result_code = RC_TIMEOUT;
            end else begin
              ticks_left_next = ticks_left - 1'b1;
            end
          end
        end
        KIND_BYTE: begin
          unique case (phase)
            PH_IDLE: ;
            PH_HUNT: last_ff_next = is_hdr;
            PH_ID: begin
              id_wrong_next = (work.data != match_id);
              run_sum_next  = work.data;
            end
            PH_LEN: begin
              len_wrong_next = (expected_len > LEN_W'(MAX_PAYLOAD)) ||
                               (work.data != BYTE_W'(expected_len) + BYTE_W'(2));
              run_sum_next   = run_sum + work.data;
            end
            PH_STATUS: begin
              run_sum_next = run_sum + work.data;
              if (id_wrong) begin
                res_push             = 1'b1;
                res_data.result_code = RC_ID;
              end else if (len_wrong) begin
                res_push             = 1'b1;
                res_data.result_code = RC_LEN;
              end else if (work.data != '0) begin
                res_push             = 1'b1;
                res_data.result_code = RC_STATUS;
              end else begin
                store_next = '0;
                idx_next   = '0;
              end
            end
            PH_DATA: begin
              run_sum_next = run_sum + work.data;
              for (int k = 0; k < MAX_PAYLOAD; k++) begin
                if (idx == IDX_W'(k)) begin
                  store_next[(MAX_PAYLOAD - 1 - k) * BYTE_W +: BYTE_W] = work.data;
                end
              end
              idx_next = idx_inc;
            end
            PH_CHECK: begin
              res_push = 1'b1;
              if (work.data == ~run_sum) begin
                res_data.result_code  = RC_OK;
                res_data.payload_data = payload_wide;
              end else begin
                res_data.result_code = RC_SUM;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      last_ff    <= 1'b0;
      id_wrong   <= 1'b0;
      len_wrong  <= 1'b0;
      run_sum    <= '0;
      idx        <= '0;
      ticks_left <= '0;
    end else begin
      phase      <= phase_next;
      last_ff    <= last_ff_next;
      id_wrong   <= id_wrong_next;
      len_wrong  <= len_wrong_next;
      run_sum    <= run_sum_next;
      idx        <= idx_next;
      ticks_left <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    store <= store_next;
  end

  sssfp_queue #(
    .T     (res_item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== verif/sssfp_frame_checker.sv =====
// Frame checker: predicts parser results from accepted beats and compares them.
module sssfp_frame_checker import sssfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  in_item_t             item,
  input  logic                 full,
  input  res_item_t            result,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fails,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;

  // Configuration copy
  logic [BYTE_W-1:0]    want_id;
  logic [LEN_W-1:0]     want_len;
  logic [TICK_W-1:0]    tick_budget;

  // Frame state copy
  phase_t               ph;
  logic                 ff_seen;
  logic                 id_bad;
  logic                 len_bad;
  logic [BYTE_W-1:0]    sum;
  logic [PAYLOAD_W-1:0] pay;
  logic [LEN_W-1:0]     idx;
  logic [TICK_W-1:0]    ticks;

  res_item_t            due_results[$];
  int                   miss_count;

  task automatic report(input string what);
    if (miss_count < 200) $display("[%0t] mismatch: %s", $time, what);
    miss_count++;
  endtask

  // Advance the frame state by one accepted beat; queue the result it ends with.
  task automatic advance_parser(input in_item_t it);
    res_item_t         r;
    bit                done;
    logic [BYTE_W-1:0] b;
    r = '0;
    done = 1'b0;
    b = it.rx_byte;
    if (it.opcode == OP_ARM) begin
      ph = PH_HUNT;
      ff_seen = 1'b0;
      id_bad = 1'b0;
      len_bad = 1'b0;
      sum = '0;
      pay = '0;
      idx = '0;
      ticks = tick_budget;
    end else if (ph != PH_IDLE) begin
      if (it.opcode == OP_TICK) begin
        if (ticks <= 1) begin
          ticks = '0;
          r.result_code = RC_TIMEOUT;
          done = 1'b1;
        end else begin
          ticks = ticks - 1'b1;
        end
      end else if (it.opcode == OP_BYTE) begin
        case (ph)
          PH_HUNT: begin
            if (ff_seen && b == HDR_BYTE) ph = PH_ID;
            ff_seen = (b == HDR_BYTE);
          end
          PH_ID: begin
            id_bad = (b != want_id);
            sum = b;
            ph = PH_LEN;
          end
          PH_LEN: begin
            len_bad = (int'(want_len) > PAYLOAD_MAX) || (b != (8'(want_len) + 8'd2));
            sum = sum + b;
            ph = PH_STATUS;
          end
          PH_STATUS: begin
            sum = sum + b;
            // id beats length beats device status
            if (id_bad) begin
              r.result_code = RC_ID;
              done = 1'b1;
            end else if (len_bad) begin
              r.result_code = RC_LEN;
              done = 1'b1;
            end else if (b != 8'd0) begin
              r.result_code = RC_STATUS;
              done = 1'b1;
            end else begin
              pay = '0;
              idx = '0;
              ph = (want_len == 0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            sum = sum + b;
            pay = pay | (64'(b) << (56 - 8 * int'(idx[2:0])));
            idx = idx + 1'b1;
            if (idx >= want_len) ph = PH_CHECK;
          end
          PH_CHECK: begin
            if (b == ~sum) begin
              r.result_code = RC_OK;
              r.payload_data = pay;
            end else begin
              r.result_code = RC_SUM;
            end
            done = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (done) begin
      ph = PH_IDLE;
      due_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    res_item_t exp_r;
    if (rst) begin
      want_id = EXPECTED_ID_RST;
      want_len = PAYLOAD_LEN_RST;
      tick_budget = TIMEOUT_RST;
      ph = PH_IDLE;
      ff_seen = 1'b0;
      id_bad = 1'b0;
      len_bad = 1'b0;
      sum = '0;
      pay = '0;
      idx = '0;
      ticks = '0;
      due_results.delete();
      miss_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPECTED_ID: want_id = cfg_data[BYTE_W-1:0];
          REG_PAYLOAD_LEN: want_len = cfg_data[LEN_W-1:0];
          REG_TIMEOUT:     tick_budget = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report($sformatf("result beat code %0d with nothing due", result.result_code));
        end else begin
          exp_r = due_results.pop_front();
          if (result.result_code != exp_r.result_code)
            report($sformatf("result_code %0d, want %0d",
                             result.result_code, exp_r.result_code));
          if (result.payload_data != exp_r.payload_data)
            report($sformatf("payload_data %h, want %h",
                             result.payload_data, exp_r.payload_data));
        end
      end
      if (push && !full) advance_parser(item);
    end
    fails <= miss_count;
    pending <= due_results.size();
  end

endmodule

// ===== verif/servo_status_frame_parser_tb.sv =====
// Testbench top: drives frames, ticks and register writes into the parser.
module servo_status_frame_parser_tb;
  import sssfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 1850;
  localparam int LIMIT = 400_000;
  // Opcode the parser must ignore, and the register index with no register.
  localparam logic [OPCODE_W-1:0]  OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  in_item_t             in_beat = '0;
  logic                 full;
  res_item_t            res_beat;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int                   fails;
  int                   pending;
  int                   sent = 0;
  int                   cycles = 0;
  int                   pop_hold = 0;
  // Set for the closing stretch: no idling on either side.
  bit                   calm = 1'b0;

  // Shadow of what the registers hold, for building frames that pass.
  logic [BYTE_W-1:0]    cur_id = EXPECTED_ID_RST;
  logic [LEN_W-1:0]     cur_len = PAYLOAD_LEN_RST;
  logic [TICK_W-1:0]    cur_to = TIMEOUT_RST;

  servo_status_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (in_beat),
    .full      (full),
    .result    (res_beat),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sssfp_frame_checker chk (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (in_beat),
    .full      (full),
    .result    (res_beat),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: pop with random stall bursts, none when calm.
  always @(posedge clk) begin
    if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
  end

  // Send one beat, now and then after an idle burst. Leave push high on return so
  // that back-to-back beats never lower and raise it in one step.
  task automatic put(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.opcode = op;
    it.rx_byte = b;
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    in_beat <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Hold cfg_valid high across the writes of one setting.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all registers; unused upper data bits carry junk the block must drop.
  task automatic set_config(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic [TICK_W-1:0] to, input bit spare);
    cfg_write(REG_EXPECTED_ID, {8'($urandom), id});
    cfg_write(REG_PAYLOAD_LEN, {12'($urandom), len});
    cfg_write(REG_TIMEOUT, to);
    if (spare) cfg_write(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_id = id;
    cur_len = len;
    cur_to = to;
  endtask

  // Stop sending, wait for every due result, then let the pipeline empty.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Force the parser idle: a frame with the wrong id always ends the wait.
  task automatic retire_wait();
    put(OP_ARM, 8'($urandom));
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, cur_id ^ 8'h01);
    put(OP_BYTE, 8'($urandom));
    put(OP_BYTE, 8'($urandom));
  endtask

  // One response wait: mostly well-formed frames, some with a single fault,
  // some cut short, some left to time out. Noisy ones add junk and ticks.
  task automatic send_frame(input bit noisy);
    logic [BYTE_W-1:0] fb[$];
    logic [BYTE_W-1:0] id_b, len_b, st_b, run, cs, pb;
    int                kind, cut, n, k, nticks;
    kind = $urandom_range(0, 15);
    cut = 1000;
    id_b = cur_id;
    len_b = {4'd0, cur_len} + 8'd2;
    st_b = 8'd0;
    if (kind == 0) id_b = cur_id ^ 8'($urandom_range(1, 255));
    if (kind == 1) len_b = len_b ^ 8'($urandom_range(1, 255));
    if (kind == 2) st_b = 8'($urandom_range(1, 255));
    if (kind == 3) cut = $urandom_range(0, int'(cur_len) + 5);
    // An FF just before arm must not pair with an FF just after it.
    if (noisy && $urandom_range(0, 3) == 0) put(OP_BYTE, HDR_BYTE);
    put(OP_ARM, 8'($urandom));
    if (kind == 5) begin
      nticks = (cur_to <= 64) ? ((cur_to == 0) ? 1 : int'(cur_to)) : $urandom_range(1, 64);
      repeat (nticks) put(OP_TICK, 8'($urandom));
      if (cur_to <= 64) cut = 0;
    end
    if (noisy) begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) put(OP_BYTE, HDR_BYTE);
        put(OP_BYTE, 8'($urandom_range(0, 254)));
      end
    end
    fb.push_back(HDR_BYTE);
    fb.push_back(HDR_BYTE);
    fb.push_back(id_b);
    fb.push_back(len_b);
    fb.push_back(st_b);
    run = id_b + len_b + st_b;
    // Bytes past the status beat only matter when the header passes.
    if (kind > 2 && cur_len <= LEN_W'(MAX_PAYLOAD_DEF)) begin
      for (k = 0; k < int'(cur_len); k++) begin
        pb = 8'($urandom);
        fb.push_back(pb);
        run = run + pb;
      end
      cs = ~run;
      if (kind == 4) cs = cs ^ 8'($urandom_range(1, 255));
      fb.push_back(cs);
    end
    for (k = 0; k < fb.size() && k < cut; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) put(OP_TICK, 8'($urandom));
      if (noisy && $urandom_range(0, 15) == 0) put(OP_SPARE, 8'($urandom));
      put(OP_BYTE, fb[k]);
    end
    if (noisy && $urandom_range(0, 3) == 0) put(OP_BYTE, 8'($urandom));
  endtask

  initial begin
    int           phase_no;
    int           stop_at;
    logic [7:0]   id_v;
    logic [3:0]   len_v;
    logic [15:0]  to_v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: id 0xFF so the id byte looks like a third header byte,
    // no payload, and a two-tick deadline.
    set_config(8'hFF, 4'd0, 16'd2, 1'b1);
    // Idle parser drops bytes and ticks; the spare opcode is always dropped.
    put(OP_BYTE, HDR_BYTE);
    put(OP_TICK, 8'h00);
    put(OP_SPARE, HDR_BYTE);
    // Clean frame with empty payload.
    put(OP_ARM, 8'h00);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, 8'hFF);
    put(OP_BYTE, 8'h02);
    put(OP_BYTE, 8'h00);
    put(OP_BYTE, 8'hFE);
    // Length mismatch.
    put(OP_ARM, 8'h00);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, 8'hFF);
    put(OP_BYTE, 8'h03);
    put(OP_BYTE, 8'h00);
    // Device status nonzero.
    put(OP_ARM, 8'h00);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, HDR_BYTE);
    put(OP_BYTE, 8'hFF);
    put(OP_BYTE, 8'h02);
    put(OP_BYTE, 8'h05);
    // Timeout on the second tick.
    put(OP_ARM, 8'h00);
    put(OP_TICK, 8'hFF);
    put(OP_TICK, 8'h00);
    drain();

    // Random phases, each under its own setting; extremes come first.
    phase_no = 0;
    while (sent < ITEMS) begin
      case (phase_no)
        0: begin id_v = 8'h00; len_v = 4'd8;  to_v = 16'hFFFF; end
        1: begin id_v = 8'hFF; len_v = 4'd0;  to_v = 16'd1; end
        2: begin
          id_v = 8'($urandom);
          len_v = 4'($urandom_range(9, 15));
          to_v = 16'($urandom_range(1, 20));
        end
        3: begin id_v = 8'($urandom); len_v = 4'($urandom_range(0, 8)); to_v = 16'd0; end
        4: begin id_v = 8'($urandom); len_v = 4'd15; to_v = 16'hFFFF; end
        default: begin
          id_v = 8'($urandom);
          len_v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
          case ($urandom_range(0, 3))
            0:       to_v = 16'($urandom_range(1, 8));
            1:       to_v = 16'($urandom_range(16, 60));
            2:       to_v = 16'($urandom);
            default: to_v = 16'hFFFF;
          endcase
        end
      endcase
      set_config(id_v, len_v, to_v, phase_no == 3);
      calm = (sent >= ITEMS - 280);
      stop_at = sent + $urandom_range(100, 200);
      while (sent < stop_at && sent < ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) put(2'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          send_frame($urandom_range(0, 3) != 0);
        end
      end
      // Close any open wait before the next register writes.
      retire_wait();
      drain();
      phase_no++;
    end

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sssfp_pkg.sv
rtl/sssfp_queue.sv
rtl/sssfp_front.sv
rtl/sssfp_back.sv
rtl/servo_status_frame_parser.sv
verif/sssfp_frame_checker.sv
verif/servo_status_frame_parser_tb.sv
